FILE: sv/cac_pkg.sv
`default_nettype none

package cac_pkg;

    // window and channel geometry
    localparam int WINDOW_LEN   = 20;
    localparam int NUM_CHANNELS = 4;
    localparam int CAL_POINTS   = 10;

    localparam int SAMP_W = 12;
    localparam int CH_W   = $clog2(NUM_CHANNELS);
    localparam int CNT_W  = $clog2(WINDOW_LEN);
    localparam int SUM_W  = SAMP_W + $clog2(WINDOW_LEN);
    localparam int MA_W   = 11;
    localparam int SEG_W  = $clog2(CAL_POINTS);

    // divide by twenty as a shift by two, then multiply by a reciprocal of five
    localparam int QTR_W     = SUM_W - 2;
    localparam int RECIP5    = 26215;
    localparam int RECIP_SH  = 17;
    localparam int AVG_PRD_W = 2 * QTR_W;

    // interpolation: dy * dx stays below dy * span, the quotient below dy
    localparam int NUM_W   = 17;
    localparam int QUO_W   = 8;
    localparam int QIDX_W  = $clog2(QUO_W);
    localparam int TRIAL_W = NUM_W + QUO_W;

    // calibration table, adc codes against milliamps
    localparam logic [SAMP_W-1:0] CAL_ADC [CAL_POINTS] = '{
        12'd0, 12'd615, 12'd806, 12'd1026, 12'd1755,
        12'd2236, 12'd2377, 12'd2440, 12'd2508, 12'd2557
    };
    localparam logic [MA_W-1:0] CAL_MA [CAL_POINTS] = '{
        11'd0, 11'd180, 11'd220, 11'd250, 11'd410,
        11'd640, 11'd850, 11'd1000, 11'd1210, 11'd1410
    };

    typedef logic [NUM_CHANNELS-1:0][SUM_W-1:0] t_sums;

    typedef struct packed {
        logic [SAMP_W-1:0] sample_ch0;
        logic [SAMP_W-1:0] sample_ch1;
        logic [SAMP_W-1:0] sample_ch2;
        logic [SAMP_W-1:0] sample_ch3;
    } t_samp;

    typedef struct packed {
        logic [CH_W-1:0]   channel;
        logic [SAMP_W-1:0] average;
        logic [MA_W-1:0]   milliamps;
        logic              last;
    } t_res;

    // front part to queue
    typedef struct packed {
        logic  push;
        t_sums sums;
    } t_q_wr;

    // queue to back part
    typedef struct packed {
        logic  full;
        logic  valid;
        t_sums sums;
    } t_q_rd;

endpackage

`default_nettype wire

FILE: sv/cac_if.sv
`default_nettype none

interface cac_samp_if import cac_pkg::*; ();
    logic  valid;
    logic  ready;
    t_samp data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface cac_res_if import cac_pkg::*; ();
    logic valid;
    logic ready;
    t_res data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/cac_fifo.sv
`default_nettype none

module cac_fifo import cac_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_q_wr i_wr,
    input  wire logic  i_pop,
    output t_q_rd      o_rd
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    t_sums            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp, n_wp;
    logic [PTR_W-1:0] r_rp, n_rp;
    logic [PTR_W:0]   r_cnt, n_cnt;
    logic             do_push;
    logic             do_pop;

    // status toward both sides
    assign o_rd.full  = (r_cnt == (PTR_W+1)'(DEPTH));
    assign o_rd.valid = (r_cnt != '0);
    assign o_rd.sums  = r_mem[r_rp];

    assign do_push = i_wr.push && !o_rd.full;
    assign do_pop  = i_pop && o_rd.valid;

    // pointer and fill count update
    always_comb begin
        n_wp  = do_push ? r_wp + PTR_W'(1) : r_wp;
        n_rp  = do_pop ? r_rp + PTR_W'(1) : r_rp;
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + (PTR_W+1)'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - (PTR_W+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_wr.sums;
        end
    end

endmodule

`default_nettype wire

FILE: sv/cac_front.sv
`default_nettype none

module cac_front import cac_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cac_samp_if.sink   i_samp,
    input  wire t_q_rd i_q,
    output t_q_wr      o_wr
);

    t_sums                    r_sums;
    t_sums                    n_sums;
    t_sums                    sums_add;
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic [SAMP_W-1:0]        samp [NUM_CHANNELS];
    logic                     last_round;
    logic                     accept;

    assign samp[0] = i_samp.data.sample_ch0;
    assign samp[1] = i_samp.data.sample_ch1;
    assign samp[2] = i_samp.data.sample_ch2;
    assign samp[3] = i_samp.data.sample_ch3;

    assign last_round   = (r_cnt == CNT_W'(WINDOW_LEN - 1));
    // stall only when a finished window has no queue entry to go to
    assign i_samp.ready = !last_round || !i_q.full;
    assign accept       = i_samp.valid && i_samp.ready;

    // per-channel accumulate, one adder per lane
    always_comb begin
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            sums_add[c] = r_sums[c] + SUM_W'(samp[c]);
        end
    end

    assign o_wr.sums = sums_add;
    assign o_wr.push = accept && last_round;

    // round count and sums, cleared at the end of a window
    always_comb begin
        n_sums = r_sums;
        n_cnt  = r_cnt;
        if (accept) begin
            if (last_round) begin
                n_sums = '0;
                n_cnt  = '0;
            end else begin
                n_sums = sums_add;
                n_cnt  = r_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sums <= '0;
            r_cnt  <= '0;
        end else begin
            r_sums <= n_sums;
            r_cnt  <= n_cnt;
        end
    end

endmodule

`default_nettype wire

FILE: sv/cac_back.sv
`default_nettype none

module cac_back import cac_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_q_rd i_q,
    output logic       o_pop,
    cac_res_if.source  o_res
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_AVG  = 6'b000010,
        S_SEG  = 6'b000100,
        S_MUL  = 6'b001000,
        S_DIV  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state              r_state, n_state;
    t_sums               r_sums;
    logic [CH_W-1:0]     r_ch;
    logic [SAMP_W-1:0]   r_avg;
    logic                r_lo;
    logic                r_hi;
    logic [SEG_W-1:0]    r_seg;
    logic [SAMP_W-1:0]   r_dx;
    logic [NUM_W-1:0]    r_num;
    logic [SAMP_W-1:0]   r_span;
    logic [MA_W-1:0]     r_y1;
    logic [QUO_W-1:0]    r_quo;
    logic [QIDX_W-1:0]   r_qidx;
    t_res                r_res;
    logic                r_res_vld;

    logic [QTR_W-1:0]     qtr;
    logic [AVG_PRD_W-1:0] avg_prd;
    logic [SEG_W-1:0]     seg;
    logic [MA_W-1:0]      dy;
    logic [SAMP_W-1:0]    span;
    logic [NUM_W+SAMP_W-1:0] prd;
    logic [TRIAL_W-1:0]   trial;
    logic                 fits;
    logic                 out_free;
    logic [MA_W-1:0]      ma;

    assign o_pop       = (r_state == S_IDLE) && i_q.valid;
    assign o_res.valid = r_res_vld;
    assign o_res.data  = r_res;
    assign out_free    = !r_res_vld || o_res.ready;

    // sum / 20 as (sum >> 2) * reciprocal of five
    assign qtr     = r_sums[r_ch][SUM_W-1:2];
    assign avg_prd = AVG_PRD_W'(qtr) * AVG_PRD_W'(RECIP5);

    // segment index: number of inner breakpoints at or below the average
    always_comb begin
        seg = '0;
        for (int i = 1; i < CAL_POINTS - 1; i++) begin
            if (r_avg >= CAL_ADC[i]) begin
                seg = seg + SEG_W'(1);
            end
        end
    end

    // slope numerator over the bracketing segment
    assign dy   = CAL_MA[r_seg + SEG_W'(1)] - CAL_MA[r_seg];
    assign span = CAL_ADC[r_seg + SEG_W'(1)] - CAL_ADC[r_seg];
    assign prd  = (NUM_W+SAMP_W)'(dy) * (NUM_W+SAMP_W)'(r_dx);

    // one restoring divide step a cycle, quotient msb first
    assign trial = TRIAL_W'(r_span) << r_qidx;
    assign fits  = TRIAL_W'(r_num) >= trial;

    // clamp at both table ends
    always_comb begin
        if (r_lo) begin
            ma = CAL_MA[0];
        end else if (r_hi) begin
            ma = CAL_MA[CAL_POINTS-1];
        end else begin
            ma = r_y1 + MA_W'(r_quo);
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_q.valid) n_state = S_AVG;
            S_AVG:  n_state = S_SEG;
            S_SEG:  n_state = S_MUL;
            S_MUL:  n_state = S_DIV;
            S_DIV:  if (r_qidx == '0) n_state = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    n_state = (r_ch == CH_W'(NUM_CHANNELS - 1)) ? S_IDLE : S_AVG;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_res_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && out_free) begin
                r_res_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_res_vld <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_sums <= i_q.sums;
                r_ch   <= '0;
            end
            S_AVG: begin
                r_avg <= avg_prd[RECIP_SH +: SAMP_W];
            end
            S_SEG: begin
                r_lo  <= (r_avg <= CAL_ADC[0]);
                r_hi  <= (r_avg >= CAL_ADC[CAL_POINTS-1]);
                r_seg <= seg;
                r_dx  <= r_avg - CAL_ADC[seg];
            end
            S_MUL: begin
                r_num  <= prd[NUM_W-1:0];
                r_span <= span;
                r_y1   <= CAL_MA[r_seg];
                r_quo  <= '0;
                r_qidx <= QIDX_W'(QUO_W - 1);
            end
            S_DIV: begin
                if (fits) begin
                    r_num <= r_num - NUM_W'(trial);
                end
                r_quo[r_qidx] <= fits;
                r_qidx        <= r_qidx - QIDX_W'(1);
            end
            S_OUT: begin
                if (out_free) begin
                    r_res.channel   <= r_ch;
                    r_res.average   <= r_avg;
                    r_res.milliamps <= ma;
                    r_res.last      <= (r_ch == CH_W'(NUM_CHANNELS - 1));
                    r_ch            <= r_ch + CH_W'(1);
                end
            end
            default: begin
                r_ch <= r_ch;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: sv/current_average_and_calibrate_top.sv
`default_nettype none

// Four-channel current averager: each transaction on i_samp carries one 12-bit
// sample per channel and is summed into that channel's window. Every twentieth
// transaction closes a window, and four results follow on o_res in channel
// order (last set on channel 3), each with the truncated window average and a
// milliamp value interpolated from the calibration table and clamped to
// 0..1410. Within a window a round is taken every cycle. Closed windows wait
// in a two-entry queue; the back part works through one result at a time
// (reciprocal multiply, segment lookup, slope multiply, an eight-step divide,
// output load), and once the queue is full the closing round of the next
// window waits for space.

module current_average_and_calibrate_top import cac_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    cac_samp_if.sink  i_samp,
    cac_res_if.source o_res
);

    t_q_wr q_wr;
    t_q_rd q_rd;
    logic  q_pop;

    // accumulate rounds, close windows
    cac_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_samp  (i_samp),
        .i_q     (q_rd),
        .o_wr    (q_wr)
    );

    // closed windows waiting for calibration
    cac_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_pop   (q_pop),
        .o_rd    (q_rd)
    );

    // average and calibrate one channel at a time
    cac_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q     (q_rd),
        .o_pop   (q_pop),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire
